>>> hw/rtl/dnsd_pkg.sv
`timescale 1ns / 1ps

package dnsd_pkg;

   // Width of a message position: it can hold any length up to the largest
   // message_len, which is one more than the last byte offset.
   localparam int POS_W = 10;

   // Width of a compression pointer target (14 bits of offset).
   localparam int TARGET_W = 14;

   // Pointer marker bits and label length mask of a name byte.
   localparam logic [1:0] PTR_MARK = 2'b11;
   localparam logic [7:0] LEN_MASK = 8'h3F;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_DECODE = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_LABEL       = 3'd0,
      ST_DONE        = 3'd1,
      ST_NO_INPUT    = 3'd2,
      ST_BAD_HEADER  = 3'd3,
      ST_BAD_POINTER = 3'd4,
      ST_OVERRUN     = 3'd5,
      ST_EMPTY       = 3'd6,
      ST_TOO_MANY    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_EXAM,
      S_FETCH_LO,
      S_POINTER
   } state_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [8:0]   byte_addr;
      logic [7:0]   byte_value;
      logic [8:0]   start_offset;
      logic [9:0]   message_len;
   } req_item_type;

   typedef struct packed {
      logic [8:0] label_start;
      logic [5:0] label_len;
      logic [9:0] end_pos;
      status_type status;
      logic       last;
   } rsp_item_type;

   // Operands of the shared add and compare unit.
   typedef struct packed {
      logic [TARGET_W-1:0] a;
      logic [5:0]          b;
      logic                carry;
      logic [POS_W-1:0]    limit;
   } alu_ctl_type;

   typedef struct packed {
      logic [TARGET_W:0] sum;
      logic              reach;
   } alu_res_type;

endpackage

>>> hw/rtl/dns_name_decompressor.sv
`timescale 1ns / 1ps
// A write item gives no result; busy stays low. A decode item gives one result per label
// and a final result: a store read and an examine step per label, two of each per
// compression pointer (set by the single registered read port of the message store),
// and the final result in the cycle after the terminating byte is examined.
// With an empty window the final result is out in the cycle after acceptance. Results cannot
// be stalled. Synchronous reset idles the sequencer and drops any pending result.
module dns_name_decompressor #(
   parameter int MSG_BYTES  = 512,
   parameter int MAX_LABELS = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dnsd_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output dnsd_pkg::rsp_item_type rsp_item
);

   localparam int AW = $clog2(MSG_BYTES);
   localparam int RW = 21;
   localparam logic [16:0] MSG_LIM = 17'(MSG_BYTES);

   // Message store. Entries are undefined until written.
   logic [7:0] store_mem [MSG_BYTES];

   dnsd_pkg::state_type state_ff, state_in;

   logic [dnsd_pkg::POS_W-1:0] walk_ff, walk_in;
   logic [dnsd_pkg::POS_W-1:0] lowest_ff, lowest_in;
   logic [dnsd_pkg::POS_W-1:0] follow_ff, follow_in;
   logic [dnsd_pkg::POS_W-1:0] len_ff, len_in;
   logic                       seen_ff, seen_in;
   logic [5:0]                 count_ff, count_in;
   logic [5:0]                 hi_ff, hi_in;
   logic [7:0]                 rd_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   dnsd_pkg::rsp_item_type     rsp_item_ff, rsp_item_in;

   logic                       accept;
   logic                       is_decode;
   logic [dnsd_pkg::POS_W-1:0] len_clamp;
   logic [dnsd_pkg::POS_W-1:0] start_pos;
   logic                       no_input;
   logic [RW-1:0]              wr_rem;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr;
   logic [dnsd_pkg::POS_W-1:0] walk_plus1;
   logic [dnsd_pkg::POS_W-1:0] follow_plus1;
   logic                       byte_zero;
   logic                       byte_ptr;
   logic                       byte_bad;

   dnsd_pkg::alu_ctl_type alu_ctl;
   dnsd_pkg::alu_res_type alu_res;

   // The block is busy whenever the sequencer is away from idle.
   assign busy      = state_ff != dnsd_pkg::S_IDLE;
   assign accept    = start && !busy;
   assign is_decode = req_item.req_type == dnsd_pkg::REQ_DECODE;

   // A length above the store size is taken as the store size.
   assign len_clamp = ({7'd0, req_item.message_len} > MSG_LIM) ?
                      MSG_LIM[dnsd_pkg::POS_W-1:0] : req_item.message_len;
   assign start_pos = {1'b0, req_item.start_offset};
   assign no_input  = start_pos >= len_clamp;

   // The write address wraps at the store size. The address is below 512, so for a store
   // of at least 32 bytes four conditional subtractions of the size shifted by three, two,
   // one and nought places leave the remainder.
   always_comb begin
      wr_rem = RW'(req_item.byte_addr);
      for (int k = 3; k >= 0; k--) begin
         if (wr_rem >= (RW'(MSG_BYTES) << k)) begin
            wr_rem = wr_rem - (RW'(MSG_BYTES) << k);
         end
      end
   end

   assign wr_addr = AW'(wr_rem);

   // Every read that the walk uses is of a position below the message length, hence inside the store.
   assign rd_addr = AW'(walk_ff);

   always_ff @(posedge clock) begin
      if (accept && !is_decode) begin
         store_mem[wr_addr] <= req_item.byte_value;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Classification of the byte just read.
   assign byte_zero = rd_data_ff == 8'd0;
   assign byte_ptr  = rd_data_ff[7:6] == dnsd_pkg::PTR_MARK;
   assign byte_bad  = (rd_data_ff[7:6] != 2'b00) && !byte_ptr;

   assign walk_plus1   = walk_ff + 10'd1;
   assign follow_plus1 = follow_ff + 10'd1;

   // The shared unit checks the label end or the pointer's second byte against the
   // length while examining, and the pointer target against the lowest target so far
   // in the pointer step.
   always_comb begin
      alu_ctl.a     = {{(dnsd_pkg::TARGET_W - dnsd_pkg::POS_W){1'b0}}, walk_ff};
      alu_ctl.b     = byte_ptr ? 6'd0 : (rd_data_ff[5:0] & dnsd_pkg::LEN_MASK[5:0]);
      alu_ctl.carry = 1'b1;
      alu_ctl.limit = len_ff;
      if (state_ff == dnsd_pkg::S_POINTER) begin
         alu_ctl.a     = {hi_ff, rd_data_ff};
         alu_ctl.b     = 6'd0;
         alu_ctl.carry = 1'b0;
         alu_ctl.limit = lowest_ff;
      end
   end

   dnsd_addcmp u_addcmp (
      .ctl (alu_ctl),
      .res (alu_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dnsd_pkg::S_IDLE: begin
            if (accept && is_decode && !no_input) begin
               state_in = dnsd_pkg::S_FETCH;
            end
         end
         dnsd_pkg::S_FETCH: begin
            state_in = dnsd_pkg::S_EXAM;
         end
         dnsd_pkg::S_EXAM: begin
            priority if (byte_zero || byte_bad) begin
               state_in = dnsd_pkg::S_IDLE;
            end else if (byte_ptr) begin
               state_in = alu_res.reach ? dnsd_pkg::S_IDLE : dnsd_pkg::S_FETCH_LO;
            end else if (alu_res.reach || count_ff >= 6'(MAX_LABELS)) begin
               state_in = dnsd_pkg::S_IDLE;
            end else begin
               state_in = dnsd_pkg::S_FETCH;
            end
         end
         dnsd_pkg::S_FETCH_LO: begin
            state_in = dnsd_pkg::S_POINTER;
         end
         dnsd_pkg::S_POINTER: begin
            state_in = alu_res.reach ? dnsd_pkg::S_IDLE : dnsd_pkg::S_FETCH;
         end
         default: begin
            state_in = dnsd_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs and walk registers.
   always_comb begin
      walk_in      = walk_ff;
      lowest_in    = lowest_ff;
      follow_in    = follow_ff;
      len_in       = len_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      hi_in        = hi_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = '{label_start: 9'd0, label_len: 6'd0, end_pos: 10'd0,
                       status: dnsd_pkg::ST_DONE, last: 1'b1};
      unique case (state_ff)
         dnsd_pkg::S_IDLE: begin
            if (accept && is_decode) begin
               walk_in   = start_pos;
               follow_in = start_pos;
               lowest_in = len_clamp;
               len_in    = len_clamp;
               seen_in   = 1'b0;
               count_in  = 6'd0;
               if (no_input) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = dnsd_pkg::ST_NO_INPUT;
               end
            end
         end
         dnsd_pkg::S_EXAM: begin
            priority if (byte_zero) begin
               rsp_valid_in = 1'b1;
               if (count_ff == 6'd0) begin
                  rsp_item_in.status = dnsd_pkg::ST_EMPTY;
               end else begin
                  rsp_item_in.end_pos = follow_plus1;
               end
            end else if (byte_bad) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = dnsd_pkg::ST_BAD_HEADER;
            end else if (byte_ptr) begin
               if (alu_res.reach) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = dnsd_pkg::ST_BAD_HEADER;
               end else begin
                  // The end position is fixed by the first pointer met.
                  walk_in = alu_res.sum[dnsd_pkg::POS_W-1:0];
                  hi_in   = rd_data_ff[5:0];
                  seen_in = 1'b1;
                  if (!seen_ff) begin
                     follow_in = alu_res.sum[dnsd_pkg::POS_W-1:0];
                  end
               end
            end else if (alu_res.reach) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = dnsd_pkg::ST_OVERRUN;
            end else if (count_ff >= 6'(MAX_LABELS)) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = dnsd_pkg::ST_TOO_MANY;
            end else begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.label_start = walk_plus1[8:0];
               rsp_item_in.label_len   = rd_data_ff[5:0];
               rsp_item_in.status      = dnsd_pkg::ST_LABEL;
               rsp_item_in.last        = 1'b0;
               count_in                = count_ff + 6'd1;
               walk_in                 = alu_res.sum[dnsd_pkg::POS_W-1:0];
               if (!seen_ff) begin
                  follow_in = alu_res.sum[dnsd_pkg::POS_W-1:0];
               end
            end
         end
         dnsd_pkg::S_POINTER: begin
            // A pointer must land strictly below every earlier target.
            if (alu_res.reach) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = dnsd_pkg::ST_BAD_POINTER;
            end else begin
               lowest_in = alu_res.sum[dnsd_pkg::POS_W-1:0];
               walk_in   = alu_res.sum[dnsd_pkg::POS_W-1:0];
            end
         end
         dnsd_pkg::S_FETCH, dnsd_pkg::S_FETCH_LO: begin
            rsp_valid_in = 1'b0;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnsd_pkg::S_IDLE;
         walk_ff      <= '0;
         lowest_ff    <= '0;
         follow_ff    <= '0;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         lowest_ff    <= lowest_in;
         follow_ff    <= follow_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      hi_ff       <= hi_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A walk only ends by giving its final item.
   a_end_gives_final: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid && rsp_item.last)
      else $error("walk ended without a final item");

   // Label items appear only while the walk is still going.
   a_label_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> busy && rsp_item.status == dnsd_pkg::ST_LABEL)
      else $error("label item outside a walk");

   // An accepted decode either starts a walk or answers at once.
   a_decode_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.req_type == dnsd_pkg::REQ_DECODE
      |=> busy || (rsp_valid && rsp_item.last))
      else $error("decode item dropped");

   // The label count never passes its bound.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 6'(MAX_LABELS))
      else $error("label count beyond bound");

endmodule

>>> hw/rtl/dnsd_addcmp.sv
`timescale 1ns / 1ps

// Shared unit: one add of a position, a label length and a carry, then a compare of
// the sum against a limit.
module dnsd_addcmp (
   input  dnsd_pkg::alu_ctl_type ctl,
   output dnsd_pkg::alu_res_type res
);

   logic [dnsd_pkg::TARGET_W:0] sum;

   assign sum = {1'b0, ctl.a}
              + {{(dnsd_pkg::TARGET_W - 5){1'b0}}, ctl.b}
              + {{dnsd_pkg::TARGET_W{1'b0}}, ctl.carry};

   assign res.sum   = sum;
   assign res.reach = sum >= {{(dnsd_pkg::TARGET_W + 1 - dnsd_pkg::POS_W){1'b0}}, ctl.limit};

endmodule
